FILE: rtl/ivd_pkg.sv
// Shared constants, breakpoint tables and stage word types for the IR distance linearizer.
package ivd_pkg;

   // Field widths
   localparam int VOLT_W  = 12;
   localparam int DIST_W  = 11;

   // Table geometry
   localparam int TABLE_SEGMENTS    = 16;
   localparam int SEGMENT_COUNT_DEF = 16;
   localparam int SEG_IDX_W         = $clog2(TABLE_SEGMENTS);
   localparam int BRK_IDX_W         = $clog2(TABLE_SEGMENTS + 1);

   // Datapath widths
   localparam int CM_W        = 7;   // breakpoint distance in cm
   localparam int OFF_W       = 9;   // Vhi - v, never above the widest span
   localparam int DD16_W      = 7;   // 16 * distance step
   localparam int NUM_W       = OFF_W + DD16_W;
   localparam int RECIP_W     = 12;
   localparam int RECIP_SHIFT = 16;  // reciprocal is floor(2^16 / span)
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int QUO_W       = 7;   // quotient never above 80

   // Stage words
   typedef struct packed {
      logic                 hit;
      logic [SEG_IDX_W-1:0] seg;
      logic [OFF_W-1:0]     off;
   } sel_word_type;

   typedef struct packed {
      logic                 hit;
      logic [SEG_IDX_W-1:0] seg;
      logic [NUM_W-1:0]     num;
   } num_word_type;

   typedef struct packed {
      logic                 hit;
      logic [SEG_IDX_W-1:0] seg;
      logic [NUM_W-1:0]     num;
      logic [QUO_W-1:0]     quo_est;
   } quo_word_type;

   // Breakpoint voltages in mV, falling
   function automatic logic [VOLT_W-1:0] brk_mv(input logic [BRK_IDX_W-1:0] idx);
      logic [VOLT_W-1:0] v;
      case (idx)
         5'd0:    v = 12'd2600;
         5'd1:    v = 12'd2100;
         5'd2:    v = 12'd1650;
         5'd3:    v = 12'd1500;
         5'd4:    v = 12'd1390;
         5'd5:    v = 12'd1130;
         5'd6:    v = 12'd980;
         5'd7:    v = 12'd850;
         5'd8:    v = 12'd750;
         5'd9:    v = 12'd680;
         5'd10:   v = 12'd620;
         5'd11:   v = 12'd570;
         5'd12:   v = 12'd540;
         5'd13:   v = 12'd500;
         5'd14:   v = 12'd470;
         5'd15:   v = 12'd430;
         5'd16:   v = 12'd410;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Breakpoint distances in cm, rising
   function automatic logic [CM_W-1:0] brk_cm(input logic [BRK_IDX_W-1:0] idx);
      logic [CM_W-1:0] d;
      case (idx)
         5'd0:    d = 7'd10;
         5'd1:    d = 7'd12;
         5'd2:    d = 7'd16;
         5'd3:    d = 7'd18;
         5'd4:    d = 7'd20;
         5'd5:    d = 7'd25;
         5'd6:    d = 7'd30;
         5'd7:    d = 7'd35;
         5'd8:    d = 7'd40;
         5'd9:    d = 7'd45;
         5'd10:   d = 7'd50;
         5'd11:   d = 7'd55;
         5'd12:   d = 7'd60;
         5'd13:   d = 7'd65;
         5'd14:   d = 7'd70;
         5'd15:   d = 7'd75;
         5'd16:   d = 7'd80;
         default: d = '0;
      endcase
      return d;
   endfunction

   // Voltage span of a segment
   function automatic logic [OFF_W-1:0] seg_span(input logic [SEG_IDX_W-1:0] seg);
      logic [VOLT_W-1:0] diff;
      diff = brk_mv(BRK_IDX_W'(seg)) - brk_mv(BRK_IDX_W'(seg) + 1'b1);
      return diff[OFF_W-1:0];
   endfunction

   // Sixteen times the distance step of a segment
   function automatic logic [DD16_W-1:0] seg_dd16(input logic [SEG_IDX_W-1:0] seg);
      logic [CM_W-1:0] dd;
      dd = brk_cm(BRK_IDX_W'(seg) + 1'b1) - brk_cm(BRK_IDX_W'(seg));
      return DD16_W'({dd, 4'b0000});
   endfunction

   // Segment start distance in 1/16 cm
   function automatic logic [DIST_W-1:0] seg_base(input logic [SEG_IDX_W-1:0] seg);
      return DIST_W'({brk_cm(BRK_IDX_W'(seg)), 4'b0000});
   endfunction

   // floor(2^16 / span); quotient estimate is low by at most one
   function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_IDX_W-1:0] seg);
      logic [RECIP_W-1:0] r;
      case (seg)
         4'd0:    r = 12'd131;
         4'd1:    r = 12'd145;
         4'd2:    r = 12'd436;
         4'd3:    r = 12'd595;
         4'd4:    r = 12'd252;
         4'd5:    r = 12'd436;
         4'd6:    r = 12'd504;
         4'd7:    r = 12'd655;
         4'd8:    r = 12'd936;
         4'd9:    r = 12'd1092;
         4'd10:   r = 12'd1310;
         4'd11:   r = 12'd2184;
         4'd12:   r = 12'd1638;
         4'd13:   r = 12'd2184;
         4'd14:   r = 12'd1638;
         4'd15:   r = 12'd3276;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/ivd_seg_select.sv
// Stage 1: segment search over the breakpoint table and offset from the upper bound.
module ivd_seg_select #(
   parameter int SEGMENT_COUNT = ivd_pkg::SEGMENT_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [ivd_pkg::VOLT_W-1:0] voltage_mv,
   output logic                       out_valid,
   output ivd_pkg::sel_word_type      out_data,
   input  logic                       out_ready
);
   import ivd_pkg::*;

   // Segments searched, held to the table
   localparam int ACTIVE = (SEGMENT_COUNT > TABLE_SEGMENTS) ? TABLE_SEGMENTS :
                           (SEGMENT_COUNT < 1) ? 1 : SEGMENT_COUNT;

   sel_word_type seg_sel;
   sel_word_type data_ff, data_in;
   logic         valid_ff, valid_in;

   // Parallel bound compares; the earliest matching segment wins
   always_comb begin
      seg_sel = '0;
      for (int i = ACTIVE - 1; i >= 0; i--) begin
         if (voltage_mv >= brk_mv(BRK_IDX_W'(i + 1)) &&
             voltage_mv <= brk_mv(BRK_IDX_W'(i))) begin
            seg_sel.hit = 1'b1;
            seg_sel.seg = SEG_IDX_W'(i);
            seg_sel.off = OFF_W'(brk_mv(BRK_IDX_W'(i)) - voltage_mv);
         end
      end
   end

   // Stage register with stall
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = (in_valid && in_ready) ? seg_sel : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/ivd_scale.sv
// Stages 2 and 3: scale the offset by the distance step, then multiply by the span reciprocal.
module ivd_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ivd_pkg::sel_word_type in_data,
   output logic                  out_valid,
   output ivd_pkg::quo_word_type out_data,
   input  logic                  out_ready
);
   import ivd_pkg::*;

   num_word_type       num_ff, num_in;
   logic               num_valid_ff, num_valid_in;
   logic               num_ready;
   quo_word_type       quo_ff, quo_in;
   logic               quo_valid_ff, quo_valid_in;
   logic               quo_ready;
   num_word_type       num_calc;
   quo_word_type       quo_calc;
   logic [PROD_W-1:0]  recip_prod;

   assign quo_ready = !quo_valid_ff || out_ready;
   assign num_ready = !num_valid_ff || quo_ready;
   assign in_ready  = num_ready;

   // Numerator: 16 * (Vhi - v) * (Dhi - Dlo)
   always_comb begin
      num_calc.hit = in_data.hit;
      num_calc.seg = in_data.seg;
      num_calc.num = NUM_W'(in_data.off * seg_dd16(in_data.seg));
   end

   assign num_valid_in = num_ready ? in_valid : num_valid_ff;
   assign num_in       = (in_valid && num_ready) ? num_calc : num_ff;

   // Quotient estimate through the reciprocal
   assign recip_prod = PROD_W'(num_ff.num * seg_recip(num_ff.seg));

   always_comb begin
      quo_calc.hit     = num_ff.hit;
      quo_calc.seg     = num_ff.seg;
      quo_calc.num     = num_ff.num;
      quo_calc.quo_est = recip_prod[RECIP_SHIFT +: QUO_W];
   end

   assign quo_valid_in = quo_ready ? num_valid_ff : quo_valid_ff;
   assign quo_in       = (num_valid_ff && quo_ready) ? quo_calc : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
         quo_valid_ff <= 1'b0;
      end else begin
         num_valid_ff <= num_valid_in;
         quo_valid_ff <= quo_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign out_valid = quo_valid_ff;
   assign out_data  = quo_ff;

endmodule

FILE: rtl/ivd_correct.sv
// Stage 4: quotient correction, add the segment base distance, result register.
module ivd_correct (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  ivd_pkg::quo_word_type      in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [ivd_pkg::DIST_W-1:0] distance_q4,
   output logic                       in_range
);
   import ivd_pkg::*;

   logic [NUM_W-1:0]  back_prod;
   logic [NUM_W-1:0]  remainder;
   logic [OFF_W-1:0]  span;
   logic              bump;
   logic [DIST_W-1:0] dist_calc;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              hit_ff, hit_in;
   logic              valid_ff, valid_in;

   // Estimate is exact or one low; one compare fixes it
   assign span      = seg_span(in_data.seg);
   assign back_prod = NUM_W'(in_data.quo_est * span);
   assign remainder = in_data.num - back_prod;
   assign bump      = (remainder >= NUM_W'(span));
   assign dist_calc = in_data.hit ?
                      DIST_W'(seg_base(in_data.seg) + DIST_W'(in_data.quo_est) + DIST_W'(bump)) :
                      '0;

   // Result register with stall
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign dist_in  = (in_valid && in_ready) ? dist_calc : dist_ff;
   assign hit_in   = (in_valid && in_ready) ? in_data.hit : hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      hit_ff  <= hit_in;
   end

   assign out_valid   = valid_ff;
   assign distance_q4 = dist_ff;
   assign in_range    = hit_ff;

endmodule

FILE: rtl/ir_voltage_to_distance.sv
// IR range sensor linearizer: four register stages of lookup and interpolation.
// A word accepted into the segment select register passes both scale registers
// and shows on rsp_valid from the result register. Throughput: one word per cycle
// while rsp_ready is high; bubbles between stages are filled while a result waits.
// Reset clears the stage valid bits only; the pipeline is empty after reset.
module ir_voltage_to_distance #(
   parameter int SEGMENT_COUNT = ivd_pkg::SEGMENT_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ivd_pkg::VOLT_W-1:0] req_voltage_mv,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ivd_pkg::DIST_W-1:0] rsp_distance_q4,
   output logic                       rsp_in_range
);
   import ivd_pkg::*;

   sel_word_type sel_data;
   logic         sel_valid, sel_ready;
   quo_word_type quo_data;
   logic         quo_valid, quo_ready;

   ivd_seg_select #(
      .SEGMENT_COUNT(SEGMENT_COUNT)
   ) u_seg_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .voltage_mv (req_voltage_mv),
      .out_valid  (sel_valid),
      .out_data   (sel_data),
      .out_ready  (sel_ready)
   );

   ivd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_data   (sel_data),
      .out_valid (quo_valid),
      .out_data  (quo_data),
      .out_ready (quo_ready)
   );

   ivd_correct u_correct (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (quo_valid),
      .in_ready    (quo_ready),
      .in_data     (quo_data),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .distance_q4 (rsp_distance_q4),
      .in_range    (rsp_in_range)
   );

endmodule

FILE: rtl/ivd_checker.sv
// Port-level assertions for the IR linearizer and the bind that attaches them.
module ivd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ivd_pkg::DIST_W-1:0] rsp_distance_q4,
   input logic                       rsp_in_range
);
   import ivd_pkg::*;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_q4) &&
                                  $stable(rsp_in_range))
      else $error("result word changed while stalled");

   // Out-of-range words carry zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_distance_q4 == '0)
      else $error("out-of-range word with nonzero distance");

   // In-range distances stay within 10 cm to 80 cm
   a_hit_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |-> rsp_distance_q4 >= DIST_W'(160) &&
                                    rsp_distance_q4 <= DIST_W'(1280))
      else $error("in-range distance outside table span");

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Empty pipeline after reset can take a word
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready right after reset");

endmodule

bind ir_voltage_to_distance ivd_checker u_ivd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_distance_q4 (rsp_distance_q4),
   .rsp_in_range    (rsp_in_range)
);
